// File: hw/rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg: shared constants, types and functions
// Fixed-point formats, register indexes and the exponential step table.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int EXP_FRAC_BITS = 12;
	localparam int VAL_W         = FRAC_BITS + 1;
	localparam int EXP_W         = 16;
	localparam int MANT_BITS     = 30;
	localparam int LOG_BITS      = 16;
	localparam int NLOG_W        = LOG_BITS + 5;
	localparam int PROD_W        = NLOG_W + EXP_W - EXP_FRAC_BITS;
	localparam int Q_W           = PROD_W - LOG_BITS;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 17;
	localparam int DIV_STEPS     = FRAC_BITS;
	// pow lane: normalize, LOG_BITS squarings, two multiply stages,
	// LOG_BITS exp steps, shift, end-point scale
	localparam int POW_LAT       = 1 + LOG_BITS + 2 + LOG_BITS + 2;
	localparam int PIPE_N        = 2 + DIV_STEPS + POW_LAT;

	localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [EXP_W-1:0] expo_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IRR_WATER = 3'd0,
		CFG_RES_OIL   = 3'd1,
		CFG_WATER_EP  = 3'd2,
		CFG_OIL_EP    = 3'd3,
		CFG_WATER_EXP = 3'd4,
		CFG_OIL_EXP   = 3'd5
	} cfg_idx_t;

	function automatic val_t sat_one(input val_t v);
		return (v > ONE) ? ONE : v;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-k) in Q1.30, floor square-root chain
	function automatic logic [63:0] exp_tab(input int k);
		logic [63:0] t;
		t = isqrt64(64'd1 << (2 * MANT_BITS - 1));
		for (int j = 2; j <= LOG_BITS; j++) begin
			if (j <= k) begin
				t = isqrt64(t << MANT_BITS);
			end
		end
		return t;
	endfunction

endpackage

// File: hw/rtl/crp_sat_if.sv
// ----------------------------------------------------------------------------
// crp_sat_if: saturation sample channel
// Valid/ready channel carrying one water saturation sample.
// ----------------------------------------------------------------------------
interface crp_sat_if;
	import crp_pkg::*;
	logic valid;
	logic ready;
	val_t water_saturation;
	modport source (output valid, output water_saturation, input ready);
	modport sink (input valid, input water_saturation, output ready);
endinterface

// File: hw/rtl/crp_perm_if.sv
// ----------------------------------------------------------------------------
// crp_perm_if: permeability result channel
// Valid/ready channel carrying normalized saturation and both permeabilities.
// ----------------------------------------------------------------------------
interface crp_perm_if;
	import crp_pkg::*;
	logic valid;
	logic ready;
	val_t normalized_saturation;
	val_t water_perm;
	val_t oil_perm;
	modport source (output valid, output normalized_saturation, output water_perm,
		output oil_perm, input ready);
	modport sink (input valid, input normalized_saturation, input water_perm,
		input oil_perm, output ready);
endinterface

// File: hw/rtl/crp_cfg_if.sv
// ----------------------------------------------------------------------------
// crp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface crp_cfg_if;
	import crp_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/crp_pow.sv
// ----------------------------------------------------------------------------
// crp_pow: pipelined end_point * x^n lane
// log2 by repeated squaring, scale by exponent, exp2 by table steps.
// ----------------------------------------------------------------------------
module crp_pow (
	input  logic          clk,
	input  logic          en,
	input  crp_pkg::val_t x,
	input  crp_pkg::expo_t n,
	input  crp_pkg::val_t end_point,
	output crp_pkg::val_t perm
);
	import crp_pkg::*;

	localparam int MB = MANT_BITS;
	localparam int LB = LOG_BITS;
	localparam int SH_BASE = MANT_BITS - FRAC_BITS;

	// special-case flag / value: travel from normalize to final shift
	logic           spf_s [0:2*LB+2];
	logic           spo_s [0:2*LB+2];
	logic [MB:0]    y_s   [0:LB];
	logic [LB-1:0]  fr_s  [0:LB];
	logic [4:0]     e_s   [0:LB];
	logic [NLOG_W-1:0] nl_s;
	logic [MB:0]    z_s   [0:LB];
	logic [Q_W-1:0] q_s   [0:LB];
	logic [LB-1:0]  r_s   [0:LB];
	val_t           p_s;
	val_t           perm_s;

	// normalize
	logic [4:0]  msb;
	logic        sp_f, sp_o;
	logic [MB:0] y0;
	always_comb begin
		msb = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (x[i]) msb = 5'(i);
		end
		y0 = (MB+1)'(x[FRAC_BITS-1:0]) << (5'(MB) - msb);
		sp_f = 1'b1;
		sp_o = 1'b1;
		if (n == '0) begin
			sp_o = 1'b1;
		end else if (x == '0) begin
			sp_o = 1'b0;
		end else if (x >= ONE) begin
			sp_o = 1'b1;
		end else begin
			sp_f = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0]   <= y0;
			e_s[0]   <= 5'(FRAC_BITS) - msb;
			fr_s[0]  <= '0;
			spf_s[0] <= sp_f;
			spo_s[0] <= sp_o;
		end
	end

	genvar k;
	generate
		for (k = 1; k <= 2*LB+2; k++) begin : g_sp
			always_ff @(posedge clk) begin
				if (en) begin
					spf_s[k] <= spf_s[k-1];
					spo_s[k] <= spo_s[k-1];
				end
			end
		end

		// log2 fraction: one squaring per stage
		for (k = 1; k <= LB; k++) begin : g_log
			logic [2*MB+1:0] sq;
			logic [MB+1:0]   t;
			assign sq = y_s[k-1] * y_s[k-1];
			assign t  = sq[2*MB+1:MB];
			always_ff @(posedge clk) begin
				if (en) begin
					y_s[k]  <= t[MB+1] ? t[MB+1:1] : t[MB:0];
					fr_s[k] <= {fr_s[k-1][LB-2:0], t[MB+1]};
					e_s[k]  <= e_s[k-1];
				end
			end
		end
	endgenerate

	logic [NLOG_W+EXP_W-1:0] lp;
	assign lp = nl_s * n;

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s   <= {e_s[LB], LB'(0)} - NLOG_W'(fr_s[LB]);
			z_s[0] <= (MB+1)'(1) << MB;
			q_s[0] <= lp[NLOG_W+EXP_W-1-(EXP_W-EXP_FRAC_BITS)+EXP_W-EXP_FRAC_BITS
				-: Q_W];
			r_s[0] <= lp[EXP_FRAC_BITS+LB-1:EXP_FRAC_BITS];
		end
	end

	generate
		// exp2 of the fraction: one table multiply per stage
		for (k = 1; k <= LB; k++) begin : g_exp
			localparam logic [MB-1:0] T = MB'(exp_tab(k));
			logic [2*MB:0] zp;
			assign zp = z_s[k-1] * T;
			always_ff @(posedge clk) begin
				if (en) begin
					z_s[k] <= r_s[k-1][LB-k] ? zp[2*MB:MB] : z_s[k-1];
					q_s[k] <= q_s[k-1];
					r_s[k] <= r_s[k-1];
				end
			end
		end
	endgenerate

	logic [Q_W:0] sh;
	val_t         pw;
	always_comb begin
		sh = (Q_W+1)'(SH_BASE) + (Q_W+1)'(q_s[LB]);
		if (spf_s[2*LB+2]) begin
			pw = spo_s[2*LB+2] ? ONE : '0;
		end else if (sh > (Q_W+1)'(62)) begin
			pw = '0;
		end else begin
			pw = VAL_W'(z_s[LB] >> sh[5:0]);
		end
	end

	logic [2*VAL_W-1:0] ep;
	logic [VAL_W:0]     eps;
	assign ep  = end_point * p_s;
	assign eps = ep[FRAC_BITS+VAL_W:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s    <= pw;
			perm_s <= (eps > (VAL_W+1)'(ONE)) ? ONE : VAL_W'(eps);
		end
	end

	assign perm = perm_s;

endmodule

// File: hw/rtl/corey_relative_permeability.sv
// ----------------------------------------------------------------------------
// corey_relative_permeability: Corey water / oil relative permeability
// Normalizes a water saturation sample and evaluates both Corey curves.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | handshake
//  cfg     | in  | index, data (register write)                   | valid/ready
//  sat     | in  | water_saturation                               | valid/ready
//  perm    | out | normalized_saturation, water_perm, oil_perm    | valid/ready
//
//  One transaction per cycle sustained while perm is ready; 55 pipe stages
//  (input, classify, 16 restoring divide steps and the 37-stage pow lanes),
//  then the output register. Depth is set by the one-bit-per-stage divider
//  and the one-multiply-per-stage log2 / exp2 chains.
//  Reset clears valid bits and the six registers; no clearing pass.
//  A stall on perm freezes the pipe once the skid entry is full; the skid
//  entry takes one more finished result while the output result waits.
// ----------------------------------------------------------------------------
module corey_relative_permeability (
	input logic clk,
	input logic arst_n,
	crp_cfg_if.sink    cfg,
	crp_sat_if.sink    sat,
	crp_perm_if.source perm
);
	import crp_pkg::*;

	// config registers
	val_t  irw_q, rso_q, wep_q, oep_q;
	expo_t wex_q, oex_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irw_q <= '0;
			rso_q <= '0;
			wep_q <= '0;
			oep_q <= '0;
			wex_q <= '0;
			oex_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IRR_WATER: irw_q <= cfg.data;
				CFG_RES_OIL:   rso_q <= cfg.data;
				CFG_WATER_EP:  wep_q <= cfg.data;
				CFG_OIL_EP:    oep_q <= cfg.data;
				CFG_WATER_EXP: wex_q <= cfg.data[EXP_W-1:0];
				CFG_OIL_EXP:   oex_q <= cfg.data[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	// derived config; registers must only change while the pipe is empty (user's duty, not enforced)
	val_t         swir, sor, den;
	logic [VAL_W:0] sum_ir;
	logic         den_ok;
	assign swir   = sat_one(irw_q);
	assign sor    = sat_one(rso_q);
	assign sum_ir = {1'b0, swir} + {1'b0, sor};
	assign den_ok = sum_ir < {1'b0, ONE};
	assign den    = VAL_W'({1'b0, ONE} - sum_ir);

	// pipeline control: whole pipe moves unless the skid entry is full
	logic             adv;
	logic             vld_s [0:PIPE_N-1];
	logic             ov_q, sk_q;

	assign adv       = !sk_q;
	assign sat.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_N; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= sat.valid;
			for (int i = 1; i < PIPE_N; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: input
	val_t sw_s1;
	always_ff @(posedge clk) begin
		if (adv) sw_s1 <= sat_one(sat.water_saturation);
	end

	// stage 2: classify, start the division (quotient used only where num < den)
	val_t num;
	assign num = sw_s1 - swir;

	logic           fz_s [0:DIV_STEPS];
	logic           fo_s [0:DIV_STEPS];
	val_t           dr_s [0:DIV_STEPS];
	logic [FRAC_BITS-1:0] dq_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			fz_s[0] <= !den_ok || (sw_s1 <= swir);
			fo_s[0] <= num >= den;
			dr_s[0] <= num;
			dq_s[0] <= '0;
		end
	end

	// restoring divider, one quotient bit per stage
	genvar k;
	generate
		for (k = 1; k <= DIV_STEPS; k++) begin : g_div
			logic [VAL_W:0] r2;
			logic           ge;
			assign r2 = {dr_s[k-1], 1'b0};
			assign ge = r2 >= {1'b0, den};
			always_ff @(posedge clk) begin
				if (adv) begin
					dr_s[k] <= ge ? VAL_W'(r2 - {1'b0, den}) : VAL_W'(r2);
					dq_s[k] <= {dq_s[k-1][FRAC_BITS-2:0], ge};
					fz_s[k] <= fz_s[k-1];
					fo_s[k] <= fo_s[k-1];
				end
			end
		end
	endgenerate

	val_t swn, swn_c;
	always_comb begin
		priority if (fz_s[DIV_STEPS]) swn = '0;
		else if (fo_s[DIV_STEPS])     swn = ONE;
		else                          swn = {1'b0, dq_s[DIV_STEPS]};
	end
	assign swn_c = ONE - swn;

	// swn rides alongside the pow lanes
	val_t sn_s [0:POW_LAT-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			sn_s[0] <= swn;
			for (int i = 1; i < POW_LAT; i++) sn_s[i] <= sn_s[i-1];
		end
	end

	val_t wp, op;

	crp_pow u_water (
		.clk(clk), .en(adv), .x(swn), .n(wex_q), .end_point(sat_one(wep_q)),
		.perm(wp)
	);

	crp_pow u_oil (
		.clk(clk), .en(adv), .x(swn_c), .n(oex_q), .end_point(sat_one(oep_q)),
		.perm(op)
	);

	// output register and skid entry
	logic pop, last_v;
	val_t ns_q, wp_q, op_q, sk_ns_q, sk_wp_q, sk_op_q;

	assign pop    = ov_q && perm.ready;
	assign last_v = vld_s[PIPE_N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_q <= 1'b0;
		end else if (sk_q) begin
			if (pop) sk_q <= 1'b0;
		end else if (last_v) begin
			if (!ov_q || pop) ov_q <= 1'b1;
			else              sk_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_q) begin
			if (pop) begin
				ns_q <= sk_ns_q;
				wp_q <= sk_wp_q;
				op_q <= sk_op_q;
			end
		end else if (last_v) begin
			if (!ov_q || pop) begin
				ns_q <= sn_s[POW_LAT-1];
				wp_q <= wp;
				op_q <= op;
			end else begin
				sk_ns_q <= sn_s[POW_LAT-1];
				sk_wp_q <= wp;
				sk_op_q <= op;
			end
		end
	end

	assign perm.valid                 = ov_q;
	assign perm.normalized_saturation = ns_q;
	assign perm.water_perm            = wp_q;
	assign perm.oil_perm              = op_q;

	// skid only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_q |-> ov_q) else $error("skid full without output");

	// a full skid entry drains only through a taken result
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sk_q) |-> $past(pop)) else $error("skid lost");

	// results never exceed one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (ns_q <= ONE && wp_q <= ONE && op_q <= ONE))
		else $error("result above one");

	// stalled pipe holds its end stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[PIPE_N-1])) else $error("pipe moved in stall");

endmodule
